/* design/scpd_pkg.sv */
// types, codes and constants shared by the sum-checked packet deframer
package scpd_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] PH_SYNC1  = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_HEADER = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SUM_ERR   = 3'd1;
    localparam logic [2:0] ST_TO_START  = 3'd2;
    localparam logic [2:0] ST_TO_HEADER = 3'd3;
    localparam logic [2:0] ST_TO_BODY   = 3'd4;
    localparam logic [2:0] ST_TO_CHECK  = 3'd5;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    localparam logic [8:0]  HEADER_BYTES    = 9'd3;
    localparam logic [8:0]  LENGTH_POSITION = 9'd2;
    localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] elapsed;
        logic [8:0]  position;
        logic [7:0]  payload_len;
        logic [7:0]  running_sum;
    } ctx_t;

    typedef struct packed {
        logic       has_result;
        logic       kind;
        logic [7:0] data_byte;
        logic [8:0] byte_index;
        logic [2:0] status;
        logic [8:0] total_length;
    } result_t;

    localparam ctx_t CTX_HUNT = '{
        phase:       PH_SYNC1,
        elapsed:     16'd0,
        position:    9'd0,
        payload_len: 8'd0,
        running_sum: 8'd0
    };

endpackage

/* design/sum_checked_packet_deframer.sv */
// sum-checked packet deframer top level: registers, handshakes and context
//
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_ready   | op, rx_byte
// output  | out       | out_valid / out_ready | kind, data_byte, byte_index, status,
//         |           |                       | total_length
// config  | in        | cfg_we                | cfg_index, cfg_data
//
// one transaction per cycle in both directions while the output is not stalled; a
// result is registered: the input register feeds the result register through
// the per-byte compare, add and counter update
// reset clears the context to hunting the first sync byte and the config and valid registers to 0
// a stalled output holds its result while one more input transaction is held
module sum_checked_packet_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [8:0]  byte_index,
    output logic [2:0]  status,
    output logic [8:0]  total_length,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import scpd_pkg::*;

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] timeout_reg;

    logic        hold_valid_reg;
    logic        hold_op_reg;
    logic [7:0]  hold_byte_reg;

    ctx_t        ctx_reg;
    ctx_t        ctx_next;
    result_t     res_next;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance   = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'd0;
            sync_second_reg <= 8'd0;
            timeout_reg     <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                REG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_op_reg   <= op;
            hold_byte_reg <= rx_byte;
        end
    end

    scpd_step u_step
    (
        .ctx_cur       (ctx_reg),
        .op_in         (hold_op_reg),
        .byte_in       (hold_byte_reg),
        .sync_first    (sync_first_reg),
        .sync_second   (sync_second_reg),
        .timeout_ticks (timeout_reg),
        .ctx_next      (ctx_next),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg       <= CTX_HUNT;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            ctx_reg       <= ctx_next;
            out_valid_reg <= res_next.has_result;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign data_byte    = out_reg.data_byte;
    assign byte_index   = out_reg.byte_index;
    assign status       = out_reg.status;
    assign total_length = out_reg.total_length;

`ifndef SYNTH
    a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_STATUS
            |-> out_reg.data_byte == 8'd0 && out_reg.byte_index == 9'd0)
        else $error("status result carries byte fields");

    a_length_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.total_length != 9'd0
            |-> out_reg.kind == KIND_STATUS && out_reg.status == ST_OK)
        else $error("total length on a non-ok result");

    a_status_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.has_result && res_next.kind == KIND_STATUS
            |=> ctx_reg.phase == PH_SYNC1 && ctx_reg.position == 9'd0
                && ctx_reg.running_sum == 8'd0)
        else $error("context not cleared after status result");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> hold_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a held transaction");
`endif

endmodule

/* design/scpd_step.sv */
// per-transaction deframing logic: next context and result from one input item
module scpd_step
(
    input  scpd_pkg::ctx_t    ctx_cur,
    input  logic              op_in,
    input  logic [7:0]        byte_in,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    input  logic [15:0]       timeout_ticks,
    output scpd_pkg::ctx_t    ctx_next,
    output scpd_pkg::result_t res
);
    import scpd_pkg::*;

    ctx_t       ctx;
    logic [8:0] pos_inc;
    logic [7:0] len_new;
    logic [7:0] sum_new;
    logic [2:0] tick_status;

    always_comb
    begin
        ctx = (ctx_cur.phase > PH_CHECK) ? CTX_HUNT : ctx_cur;
    end

    assign pos_inc = ctx.position + 9'd1;
    assign sum_new = ctx.running_sum + byte_in;
    assign len_new = (ctx.position == LENGTH_POSITION) ? byte_in : ctx.payload_len;

    always_comb
    begin
        case (ctx.phase)
            PH_HEADER: tick_status = ST_TO_HEADER;
            PH_BODY:   tick_status = ST_TO_BODY;
            PH_CHECK:  tick_status = ST_TO_CHECK;
            default:   tick_status = ST_TO_START;
        endcase
    end

    always_comb
    begin
        ctx_next = ctx;
        res      = '0;
        if (op_in == OP_TICK)
        begin
            if (timeout_ticks != 16'd0 && ctx.elapsed >= timeout_ticks)
            begin
                res.has_result = 1'b1;
                res.kind       = KIND_STATUS;
                res.status     = tick_status;
                ctx_next       = CTX_HUNT;
            end
            else if (ctx.elapsed != TICKS_MAX)
            begin
                ctx_next.elapsed = ctx.elapsed + 16'd1;
            end
        end
        else
        begin
            unique case (ctx.phase)
                PH_SYNC1:
                begin
                    if (byte_in == sync_first)
                    begin
                        ctx_next.phase = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (byte_in == sync_second)
                    begin
                        ctx_next       = CTX_HUNT;
                        ctx_next.phase = PH_HEADER;
                    end
                    else
                    begin
                        ctx_next.phase = PH_SYNC1;
                    end
                end
                PH_HEADER:
                begin
                    res.has_result       = 1'b1;
                    res.kind             = KIND_BYTE;
                    res.data_byte        = byte_in;
                    res.byte_index       = ctx.position;
                    ctx_next.running_sum = sum_new;
                    ctx_next.payload_len = len_new;
                    ctx_next.position    = pos_inc;
                    if (pos_inc >= HEADER_BYTES)
                    begin
                        ctx_next.phase   = (len_new == 8'd0) ? PH_CHECK : PH_BODY;
                        ctx_next.elapsed = 16'd0;
                    end
                end
                PH_BODY:
                begin
                    res.has_result       = 1'b1;
                    res.kind             = KIND_BYTE;
                    res.data_byte        = byte_in;
                    res.byte_index       = ctx.position;
                    ctx_next.running_sum = sum_new;
                    ctx_next.position    = pos_inc;
                    if (pos_inc >= HEADER_BYTES + {1'b0, ctx.payload_len})
                    begin
                        ctx_next.phase   = PH_CHECK;
                        ctx_next.elapsed = 16'd0;
                    end
                end
                PH_CHECK:
                begin
                    res.has_result = 1'b1;
                    res.kind       = KIND_STATUS;
                    if (byte_in != ctx.running_sum)
                    begin
                        res.status = ST_SUM_ERR;
                    end
                    else
                    begin
                        res.status       = ST_OK;
                        res.total_length = HEADER_BYTES + {1'b0, ctx.payload_len};
                    end
                    ctx_next = CTX_HUNT;
                end
                default:
                begin
                    ctx_next = CTX_HUNT;
                end
            endcase
        end
    end

endmodule
